// ===== rtl/core/utrbq_pkg.sv =====
// ----------------------------------------------------------------------------
// utrbq_pkg
// shared codes, constants and the result record for the serial byte queues
// ----------------------------------------------------------------------------
package utrbq_pkg;

	// request codes
	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_READ    = 2'd1;
	localparam logic [1:0] CMD_TX_EMPTY = 2'd2;
	localparam logic [1:0] CMD_RX_EVENT = 2'd3;

	// character constants
	localparam logic [7:0] LINE_FEED    = 8'h0A;
	localparam logic [7:0] CARRIAGE_RET = 8'h0D;

	// stop bit placed above the byte in a transmit word
	localparam logic STOP_BIT = 1'b1;

	localparam int LEVEL_W = 7;

	// result of one request before the queue read data is merged in
	typedef struct packed {
		logic               tx_valid;
		logic               tx_from_ram;
		logic [7:0]         tx_byte;
		logic               rd_valid;
		logic               dropped;
		logic [LEVEL_W-1:0] tx_level;
		logic [LEVEL_W-1:0] rx_level;
	} utrbq_result_t;

endpackage

// ===== rtl/core/utrbq_byte_ram.sv =====
// ----------------------------------------------------------------------------
// utrbq_byte_ram
// byte wide queue storage, one write and one registered read port
// ----------------------------------------------------------------------------
module utrbq_byte_ram #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0]               rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	assign rdata = rdata_s1;

endmodule

// ===== rtl/core/utrbq_ctrl.sv =====
// ----------------------------------------------------------------------------
// utrbq_ctrl
// queue pointers, occupancy counts and holding register state
// ----------------------------------------------------------------------------
module utrbq_ctrl
	import utrbq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [1:0]                     cmd,
	input  logic [7:0]                     wr_byte,
	input  logic                           rx_flag,
	input  logic [7:0]                     rx_byte,
	output logic                           busy,
	output logic                           tx_we,
	output logic [$clog2(QUEUE_DEPTH)-1:0] tx_waddr,
	output logic [7:0]                     tx_wdata,
	output logic [$clog2(QUEUE_DEPTH)-1:0] tx_raddr,
	output logic                           rx_we,
	output logic [$clog2(QUEUE_DEPTH)-1:0] rx_waddr,
	output logic [7:0]                     rx_wdata,
	output logic [$clog2(QUEUE_DEPTH)-1:0] rx_raddr,
	output utrbq_result_t                  result
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUEUE_DEPTH - 1);

	logic [PTR_W-1:0] tx_head_q, tx_tail_q, rx_head_q, rx_tail_q;
	logic [CNT_W-1:0] tx_count_q, rx_count_q;
	logic             hold_empty_q;
	logic             cr_pend_q;
	logic [PTR_W-1:0] cr_addr_q;

	logic [PTR_W-1:0] tx_head_d, tx_tail_d, rx_head_d, rx_tail_d;
	logic [CNT_W-1:0] tx_count_d, rx_count_d;
	logic             hold_empty_d;
	logic             cr_set;
	logic             tx_we_c;
	logic [7:0]       tx_wdata_c;
	logic             rx_we_c;
	utrbq_result_t    res_c;

	always_comb begin
		tx_head_d    = tx_head_q;
		tx_tail_d    = tx_tail_q;
		tx_count_d   = tx_count_q;
		rx_head_d    = rx_head_q;
		rx_tail_d    = rx_tail_q;
		rx_count_d   = rx_count_q;
		hold_empty_d = hold_empty_q;
		cr_set       = 1'b0;
		tx_we_c      = 1'b0;
		tx_wdata_c   = wr_byte;
		rx_we_c      = 1'b0;
		res_c        = '0;
		unique case (cmd)
			CMD_WRITE: begin
				if (tx_count_q == '0 && hold_empty_q) begin
					// straight to the transmitter; a line feed also queues a carriage return
					res_c.tx_valid = 1'b1;
					res_c.tx_byte  = wr_byte;
					hold_empty_d   = 1'b0;
					if (wr_byte == LINE_FEED) begin
						tx_we_c    = 1'b1;
						tx_wdata_c = CARRIAGE_RET;
						tx_tail_d  = tx_tail_q + PTR_W'(1);
						tx_count_d = tx_count_q + CNT_W'(1);
					end
				end else if (tx_count_q != CNT_FULL) begin
					tx_we_c    = 1'b1;
					tx_tail_d  = tx_tail_q + PTR_W'(1);
					tx_count_d = tx_count_q + CNT_W'(1);
					if (wr_byte == LINE_FEED) begin
						if (tx_count_q != CNT_LAST) begin
							// carriage return written in the following cycle
							cr_set     = 1'b1;
							tx_tail_d  = tx_tail_q + PTR_W'(2);
							tx_count_d = tx_count_q + CNT_W'(2);
						end else begin
							res_c.dropped = 1'b1;
						end
					end
				end else begin
					res_c.dropped = 1'b1;
				end
			end
			CMD_READ: begin
				if (rx_count_q != '0) begin
					res_c.rd_valid = 1'b1;
					rx_head_d      = rx_head_q + PTR_W'(1);
					rx_count_d     = rx_count_q - CNT_W'(1);
				end
			end
			CMD_TX_EMPTY: begin
				hold_empty_d = 1'b1;
				if (tx_count_q != '0) begin
					res_c.tx_valid    = 1'b1;
					res_c.tx_from_ram = 1'b1;
					hold_empty_d      = 1'b0;
					tx_head_d         = tx_head_q + PTR_W'(1);
					tx_count_d        = tx_count_q - CNT_W'(1);
				end
			end
			CMD_RX_EVENT: begin
				if (rx_flag) begin
					if (rx_count_q != CNT_FULL) begin
						rx_we_c    = 1'b1;
						rx_tail_d  = rx_tail_q + PTR_W'(1);
						rx_count_d = rx_count_q + CNT_W'(1);
					end else begin
						res_c.dropped = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		res_c.tx_level = LEVEL_W'(tx_count_d);
		res_c.rx_level = LEVEL_W'(rx_count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_head_q    <= '0;
			tx_tail_q    <= '0;
			tx_count_q   <= '0;
			rx_head_q    <= '0;
			rx_tail_q    <= '0;
			rx_count_q   <= '0;
			hold_empty_q <= 1'b1;
			cr_pend_q    <= 1'b0;
		end else begin
			cr_pend_q <= accept && cr_set;
			if (accept) begin
				tx_head_q    <= tx_head_d;
				tx_tail_q    <= tx_tail_d;
				tx_count_q   <= tx_count_d;
				rx_head_q    <= rx_head_d;
				rx_tail_q    <= rx_tail_d;
				rx_count_q   <= rx_count_d;
				hold_empty_q <= hold_empty_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cr_set) begin
			cr_addr_q <= tx_tail_q + PTR_W'(1);
		end
	end

	assign busy     = cr_pend_q;
	assign tx_we    = cr_pend_q || (accept && tx_we_c);
	assign tx_waddr = cr_pend_q ? cr_addr_q : tx_tail_q;
	assign tx_wdata = cr_pend_q ? CARRIAGE_RET : tx_wdata_c;
	assign tx_raddr = tx_head_q;
	assign rx_we    = accept && rx_we_c;
	assign rx_waddr = rx_tail_q;
	assign rx_wdata = rx_byte;
	assign rx_raddr = rx_head_q;
	assign result   = res_c;

endmodule

// ===== rtl/core/uart_tx_rx_byte_queues.sv =====
// ----------------------------------------------------------------------------
// uart_tx_rx_byte_queues
// transmit and receive byte queues in front of a serial port
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------
//  input   | in_valid / in_ready | cmd, wr_byte, rx_flag, rx_byte
//  output  | out_valid/out_ready | tx_valid, tx_word, rd_valid, rd_byte,
//          |                     | dropped, tx_level, rx_level
//
//  one request per cycle while in_ready is high; an accepted request loads the
//  result stage and then the output register, which offers the result.
//  a queued line feed that also queues its carriage return holds in_ready low
//  for the next cycle while the single write port of the transmit queue
//  stores the carriage return
//  reset clears pointers, counts and valids; the holding register reads idle
//  a stalled output keeps one result in the result stage, after which
//  in_ready drops until the output register is taken
//
module uart_tx_rx_byte_queues
	import utrbq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  wr_byte,
	input  logic        rx_flag,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        tx_valid,
	output logic [8:0]  tx_word,
	output logic        rd_valid,
	output logic [7:0]  rd_byte,
	output logic        dropped,
	output logic [6:0]  tx_level,
	output logic [6:0]  rx_level
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	logic             accept;
	logic             busy;
	logic             s1_adv;
	logic             tx_we, rx_we;
	logic [PTR_W-1:0] tx_waddr, tx_raddr, rx_waddr, rx_raddr;
	logic [7:0]       tx_wdata, rx_wdata;
	logic [7:0]       tx_rdata, rx_rdata;
	utrbq_result_t    result;

	// result stage, read data of both queues sits alongside in the rams
	utrbq_result_t    res_s1;
	logic             valid_s1;

	// output register
	logic             out_valid_q;
	logic             tx_valid_q;
	logic [8:0]       tx_word_q;
	logic             rd_valid_q;
	logic [7:0]       rd_byte_q;
	logic             dropped_q;
	logic [6:0]       tx_level_q;
	logic [6:0]       rx_level_q;

	// result stage moves on when the output register is free or being taken
	assign s1_adv   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !busy && (!valid_s1 || s1_adv);
	assign accept   = in_valid && in_ready;

	utrbq_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (cmd),
		.wr_byte  (wr_byte),
		.rx_flag  (rx_flag),
		.rx_byte  (rx_byte),
		.busy     (busy),
		.tx_we    (tx_we),
		.tx_waddr (tx_waddr),
		.tx_wdata (tx_wdata),
		.tx_raddr (tx_raddr),
		.rx_we    (rx_we),
		.rx_waddr (rx_waddr),
		.rx_wdata (rx_wdata),
		.rx_raddr (rx_raddr),
		.result   (result)
	);

	// head entries are read on every accepted request and used only on a pop
	utrbq_byte_ram #(
		.DEPTH(QUEUE_DEPTH)
	) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_waddr),
		.wdata (tx_wdata),
		.re    (accept),
		.raddr (tx_raddr),
		.rdata (tx_rdata)
	);

	utrbq_byte_ram #(
		.DEPTH(QUEUE_DEPTH)
	) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_waddr),
		.wdata (rx_wdata),
		.re    (accept),
		.raddr (rx_raddr),
		.rdata (rx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= result;
		end
	end

	// merge queue read data and zero the fields of absent words
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			tx_valid_q <= res_s1.tx_valid;
			if (!res_s1.tx_valid) begin
				tx_word_q <= '0;
			end else if (res_s1.tx_from_ram) begin
				tx_word_q <= {STOP_BIT, tx_rdata};
			end else begin
				tx_word_q <= {STOP_BIT, res_s1.tx_byte};
			end
			rd_valid_q <= res_s1.rd_valid;
			rd_byte_q  <= res_s1.rd_valid ? rx_rdata : 8'h00;
			dropped_q  <= res_s1.dropped;
			tx_level_q <= res_s1.tx_level;
			rx_level_q <= res_s1.rx_level;
		end
	end

	assign out_valid = out_valid_q;
	assign tx_valid  = tx_valid_q;
	assign tx_word   = tx_word_q;
	assign rd_valid  = rd_valid_q;
	assign rd_byte   = rd_byte_q;
	assign dropped   = dropped_q;
	assign tx_level  = tx_level_q;
	assign rx_level  = rx_level_q;

endmodule
